/* sv/cla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cla_pkg;

  localparam int unsigned NumAddr   = 16;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned MaxCand   = 4;
  localparam int unsigned CandCntW  = 3;
  localparam logic [AddrW-1:0] NoAddress = 4'd15;

  // Operation codes; code 3 is unused and falls to a default arm
  typedef enum logic [1:0] {
    FuncAllocate = 2'd0,
    FuncRelease  = 2'd1,
    FuncClear    = 2'd2
  } cla_func_e;

  typedef enum logic [2:0] {
    DevTv           = 3'd0,
    DevPlayback     = 3'd1,
    DevAudio        = 3'd2,
    DevRecorder     = 3'd3,
    DevTuner        = 3'd4,
    DevReserved     = 3'd5,
    DevFreeUse      = 3'd6,
    DevUnregistered = 3'd7
  } cla_dev_e;

  typedef struct packed {
    logic [MaxCand-1:0][AddrW-1:0] addr;   // first candidate in entry 0
    logic [CandCntW-1:0]           count;
  } cla_cand_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             granted;
  } cla_result_t;

  // Standard candidate list for each device type, tried in order
  function automatic cla_cand_t cand_lookup(input cla_dev_e dev);
    cla_cand_t c;
    c.addr  = '0;
    c.count = 3'd1;
    unique case (dev)
      DevTv: begin
        c.addr[0] = 4'd0;
      end
      DevPlayback: begin
        c.addr[0] = 4'd4;  c.addr[1] = 4'd8;  c.addr[2] = 4'd11; c.count = 3'd3;
      end
      DevAudio: begin
        c.addr[0] = 4'd5;
      end
      DevRecorder: begin
        c.addr[0] = 4'd1;  c.addr[1] = 4'd2;  c.addr[2] = 4'd9;  c.count = 3'd3;
      end
      DevTuner: begin
        c.addr[0] = 4'd3;  c.addr[1] = 4'd6;  c.addr[2] = 4'd7;
        c.addr[3] = 4'd10; c.count = 3'd4;
      end
      DevReserved: begin
        c.addr[0] = 4'd12; c.addr[1] = 4'd13; c.count = 3'd2;
      end
      DevFreeUse: begin
        c.addr[0] = 4'd14;
      end
      DevUnregistered: begin
        c.addr[0] = 4'd15;
      end
      default: begin
        c.addr[0] = NoAddress;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/cla_alloc_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Applies one operation to the address map: candidate lookup, first-free
// pick, and the map update that goes with it.
module cla_alloc_core (
  input  wire logic [cla_pkg::NumAddr-1:0] map_i,
  input  wire logic [1:0]                  func_i,
  input  wire logic [2:0]                  device_type_i,
  input  wire logic [cla_pkg::AddrW-1:0]   address_i,
  output cla_pkg::cla_result_t             result_o,
  output logic [cla_pkg::NumAddr-1:0]      map_o
);
  import cla_pkg::*;

  cla_cand_t        cand;
  logic             found;
  logic [AddrW-1:0] pick;

  assign cand = cand_lookup(cla_dev_e'(device_type_i));

  // First candidate in list order whose bit is clear
  always_comb begin
    found = 1'b0;
    pick  = NoAddress;
    for (int i = 0; i < MaxCand; i++) begin
      if (!found && (CandCntW'(i) < cand.count) && !map_i[cand.addr[i]]) begin
        found = 1'b1;
        pick  = cand.addr[i];
      end
    end
  end

  always_comb begin
    map_o            = map_i;
    result_o.addr    = NoAddress;
    result_o.granted = 1'b0;
    unique case (cla_func_e'(func_i))
      FuncAllocate: begin
        if (found) begin
          map_o[pick]      = 1'b1;
          result_o.addr    = pick;
          result_o.granted = 1'b1;
        end
      end
      FuncRelease: begin
        map_o[address_i] = 1'b0;
        result_o.addr    = address_i;
        result_o.granted = 1'b1;
      end
      FuncClear: begin
        map_o            = '0;
        result_o.granted = 1'b1;
      end
      default: begin
        // unused code: map untouched, no grant
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/cec_logical_address_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// HDMI-CEC logical address allocator. Keeps a 16-bit map of taken logical
// addresses, cleared at reset and by a clear transaction. Allocate returns
// the first free address from the device type's standard candidate list
// (15 with granted low when none is free); release frees one address and
// echoes it; clear frees all. Every input transaction yields exactly one
// result. Transactions are taken into an input register, resolved against
// the map by a single combinational pass, and land in an output register:
// a transaction waits in the input register while an untaken result sits
// in the output register. One transaction is accepted every cycle as
// long as results are taken; with the result side stalled the block holds
// two transactions (input and output register) before in_ready_o drops.
module cec_logical_address_allocator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] func_i,
  input  wire logic [2:0] device_type_i,
  input  wire logic [3:0] address_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      alloc_addr_o,
  output logic            granted_o
);
  import cla_pkg::*;

  // Input register
  logic                s1_valid_q, s1_valid_d;
  logic [1:0]          s1_func_q;
  logic [2:0]          s1_dev_q;
  logic [AddrW-1:0]    s1_addr_q;

  // Map and result register
  logic [NumAddr-1:0]  map_q, map_d, map_next;
  cla_result_t         res, res_q;
  logic                out_valid_q, out_valid_d;

  logic in_fire, s1_fire, out_fire;

  assign out_fire   = out_valid_q && out_ready_i;
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  cla_alloc_core u_core (
    .map_i         (map_q),
    .func_i        (s1_func_q),
    .device_type_i (s1_dev_q),
    .address_i     (s1_addr_q),
    .result_o      (res),
    .map_o         (map_next)
  );

  // Control next state
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    map_d       = map_q;
    if (s1_fire) begin
      s1_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      map_d       = map_next;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      map_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      map_q       <= map_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= func_i;
      s1_dev_q  <= device_type_i;
      s1_addr_q <= address_i;
    end
    if (s1_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign alloc_addr_o = res_q.addr;
  assign granted_o    = res_q.granted;

  // A refused result always carries the no-address code
  a_refused_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.granted) |-> (res_q.addr == NoAddress))
    else $error("refused result without no-address code");

  // A granted allocation leaves its address marked taken
  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res.granted && (s1_func_q == FuncAllocate)) |=> map_q[$past(res.addr)])
    else $error("granted address not marked taken");

  // A clear empties the map
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_func_q == FuncClear)) |=> (map_q == '0))
    else $error("clear did not empty the map");

  // The map only changes when a transaction is resolved
  a_map_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(map_q))
    else $error("map changed without a transaction");

endmodule

`default_nettype wire
